/* rtl/cml_pkg.sv */
`default_nettype none

package cml_pkg;

    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int LINE_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int KW_COUNT = 6;
    localparam int KW_MAX = 6;

    localparam logic [4:0] KIND_END = 5'd0;
    localparam logic [4:0] KIND_ID = 5'd1;
    localparam logic [4:0] KIND_NUM = 5'd2;
    localparam logic [4:0] KIND_VOID = 5'd3;
    localparam logic [4:0] KIND_PLUS = 5'd9;
    localparam logic [4:0] KIND_MINUS = 5'd10;
    localparam logic [4:0] KIND_MUL = 5'd11;
    localparam logic [4:0] KIND_DIV = 5'd12;
    localparam logic [4:0] KIND_LT = 5'd13;
    localparam logic [4:0] KIND_LE = 5'd14;
    localparam logic [4:0] KIND_GT = 5'd15;
    localparam logic [4:0] KIND_GE = 5'd16;
    localparam logic [4:0] KIND_ASSIGN = 5'd17;
    localparam logic [4:0] KIND_EQ = 5'd18;
    localparam logic [4:0] KIND_NE = 5'd19;
    localparam logic [4:0] KIND_SEMI = 5'd20;
    localparam logic [4:0] KIND_COMMA = 5'd21;
    localparam logic [4:0] KIND_LPAREN = 5'd22;
    localparam logic [4:0] KIND_RPAREN = 5'd23;
    localparam logic [4:0] KIND_LSQ = 5'd24;
    localparam logic [4:0] KIND_RSQ = 5'd25;
    localparam logic [4:0] KIND_LCURLY = 5'd26;
    localparam logic [4:0] KIND_RCURLY = 5'd27;
    localparam logic [4:0] KIND_ERROR = 5'd28;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd4, 8'd3, 8'd2, 8'd4, 8'd5, 8'd6};

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] len;
    } tok_t;

    typedef struct packed {
        logic [1:0]  count;
        tok_t        tok0;
        tok_t        tok1;
        logic [15:0] line;
    } scan_out_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [7:0]  len;
        logic        last;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

`default_nettype wire

/* rtl/cml_scan.sv */
`default_nettype none

module cml_scan #(
    parameter int KEYWORD_CHARS = cml_pkg::KEYWORD_CHARS_DEF,
    parameter int LINE_WIDTH = cml_pkg::LINE_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         ch,
    output cml_pkg::scan_out_t      res
);

    localparam int IW = $clog2(KEYWORD_CHARS);

    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_ID = 4'd1;
    localparam logic [3:0] ST_NUM = 4'd2;
    localparam logic [3:0] ST_DIV = 4'd3;
    localparam logic [3:0] ST_COMMENT = 4'd4;
    localparam logic [3:0] ST_COMMENT_END = 4'd5;
    localparam logic [3:0] ST_LESS = 4'd6;
    localparam logic [3:0] ST_GREATER = 4'd7;
    localparam logic [3:0] ST_ASSIGN = 4'd8;
    localparam logic [3:0] ST_NOT = 4'd9;

    logic [3:0]            stage_reg;
    logic [3:0]            stage_next;
    logic [LINE_WIDTH-1:0] line_reg;
    logic [LINE_WIDTH-1:0] line_next;
    logic [7:0]            len_reg;
    logic [7:0]            len_next;
    logic [7:0]            letters_reg [KEYWORD_CHARS];

    logic [3:0] st_stage;
    logic       st_take;
    logic       st_bump;
    logic       st_emit;
    logic [4:0] st_kind;
    logic [7:0] st_len;

    logic       use_start;
    logic       take_cont;
    logic       bump;
    logic       first_emit;
    logic [4:0] first_kind;
    logic [7:0] first_len;
    logic       second_emit;
    logic [4:0] word_kind;
    logic       wr_en;
    logic [IW-1:0] wr_idx;

    always_comb
    begin
        logic hit;
        word_kind = cml_pkg::KIND_ID;
        for (int k = cml_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (len_reg == cml_pkg::KW_LEN[k]);
            for (int i = 0; i < cml_pkg::KW_MAX; i++)
            begin
                if (8'(i) < cml_pkg::KW_LEN[k] && letters_reg[i] != cml_pkg::KW_TEXT[k][i])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                word_kind = cml_pkg::KIND_VOID + 5'(k);
            end
        end
    end

    // What the character does when it is scanned from the start stage.
    always_comb
    begin
        st_stage = ST_START;
        st_take = 1'b0;
        st_bump = 1'b0;
        st_emit = 1'b0;
        st_kind = cml_pkg::KIND_ERROR;
        st_len = 8'd1;
        if (cml_pkg::is_letter(ch))
        begin
            st_stage = ST_ID;
            st_take = 1'b1;
        end
        else if (cml_pkg::is_digit(ch))
        begin
            st_stage = ST_NUM;
            st_take = 1'b1;
        end
        else if (cml_pkg::is_blank(ch))
        begin
            st_bump = (ch == cml_pkg::CHAR_NEWLINE);
        end
        else
        begin
            st_emit = 1'b1;
            case (ch)
                "/": begin st_stage = ST_DIV; st_emit = 1'b0; end
                "<": begin st_stage = ST_LESS; st_emit = 1'b0; end
                ">": begin st_stage = ST_GREATER; st_emit = 1'b0; end
                "=": begin st_stage = ST_ASSIGN; st_emit = 1'b0; end
                "!": begin st_stage = ST_NOT; st_emit = 1'b0; end
                cml_pkg::CHAR_NUL: begin st_kind = cml_pkg::KIND_END; st_len = 8'd0; end
                "+": st_kind = cml_pkg::KIND_PLUS;
                "-": st_kind = cml_pkg::KIND_MINUS;
                "*": st_kind = cml_pkg::KIND_MUL;
                ";": st_kind = cml_pkg::KIND_SEMI;
                ",": st_kind = cml_pkg::KIND_COMMA;
                "(": st_kind = cml_pkg::KIND_LPAREN;
                ")": st_kind = cml_pkg::KIND_RPAREN;
                "[": st_kind = cml_pkg::KIND_LSQ;
                "]": st_kind = cml_pkg::KIND_RSQ;
                "{": st_kind = cml_pkg::KIND_LCURLY;
                "}": st_kind = cml_pkg::KIND_RCURLY;
                default: st_kind = cml_pkg::KIND_ERROR;
            endcase
        end
    end

    always_comb
    begin
        use_start = 1'b0;
        take_cont = 1'b0;
        bump = 1'b0;
        first_emit = 1'b0;
        first_kind = cml_pkg::KIND_END;
        first_len = 8'd0;
        stage_next = stage_reg;
        len_next = len_reg;
        unique case (stage_reg)
            ST_ID:
            begin
                if (cml_pkg::is_letter(ch))
                begin
                    take_cont = 1'b1;
                end
                else
                begin
                    first_emit = 1'b1;
                    first_kind = word_kind;
                    first_len = len_reg;
                    use_start = 1'b1;
                end
            end
            ST_NUM:
            begin
                if (cml_pkg::is_digit(ch))
                begin
                    take_cont = 1'b1;
                end
                else
                begin
                    first_emit = 1'b1;
                    first_kind = cml_pkg::KIND_NUM;
                    first_len = len_reg;
                    use_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (ch == "*")
                begin
                    stage_next = ST_COMMENT;
                end
                else
                begin
                    first_emit = 1'b1;
                    first_kind = cml_pkg::KIND_DIV;
                    first_len = 8'd1;
                    use_start = 1'b1;
                end
            end
            ST_COMMENT:
            begin
                if (ch == "*")
                begin
                    stage_next = ST_COMMENT_END;
                end
                else if (ch == cml_pkg::CHAR_NEWLINE)
                begin
                    bump = 1'b1;
                end
                else if (ch == cml_pkg::CHAR_NUL)
                begin
                    first_emit = 1'b1;
                    stage_next = ST_START;
                    len_next = 8'd0;
                end
            end
            ST_COMMENT_END:
            begin
                if (ch == "/")
                begin
                    stage_next = ST_START;
                    len_next = 8'd0;
                end
                else if (ch == "*")
                begin
                    stage_next = ST_COMMENT_END;
                end
                else if (ch == cml_pkg::CHAR_NUL)
                begin
                    first_emit = 1'b1;
                    stage_next = ST_START;
                    len_next = 8'd0;
                end
                else
                begin
                    stage_next = ST_COMMENT;
                    bump = (ch == cml_pkg::CHAR_NEWLINE);
                end
            end
            ST_LESS, ST_GREATER, ST_ASSIGN, ST_NOT:
            begin
                first_emit = 1'b1;
                if (ch == "=")
                begin
                    first_len = 8'd2;
                    stage_next = ST_START;
                    len_next = 8'd0;
                    case (stage_reg)
                        ST_LESS: first_kind = cml_pkg::KIND_LE;
                        ST_GREATER: first_kind = cml_pkg::KIND_GE;
                        ST_ASSIGN: first_kind = cml_pkg::KIND_EQ;
                        default: first_kind = cml_pkg::KIND_NE;
                    endcase
                end
                else
                begin
                    first_len = 8'd1;
                    use_start = 1'b1;
                    case (stage_reg)
                        ST_LESS: first_kind = cml_pkg::KIND_LT;
                        ST_GREATER: first_kind = cml_pkg::KIND_GT;
                        ST_ASSIGN: first_kind = cml_pkg::KIND_ASSIGN;
                        default: first_kind = cml_pkg::KIND_ERROR;
                    endcase
                end
            end
            default:
            begin
                use_start = 1'b1;
            end
        endcase

        wr_en = 1'b0;
        wr_idx = '0;
        if (use_start)
        begin
            stage_next = st_stage;
            len_next = st_take ? 8'd1 : 8'd0;
            bump = st_bump;
            wr_en = st_take;
        end
        else if (take_cont)
        begin
            len_next = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
            wr_en = (len_reg < 8'(KEYWORD_CHARS));
            wr_idx = len_reg[IW-1:0];
        end

        line_next = (bump && line_reg != '1) ? line_reg + 1'b1 : line_reg;
        second_emit = use_start && st_emit;
    end

    always_comb
    begin
        res.line = 16'(line_reg);
        res.count = 2'(first_emit) + 2'(second_emit);
        res.tok1.kind = st_kind;
        res.tok1.len = st_len;
        if (first_emit)
        begin
            res.tok0.kind = first_kind;
            res.tok0.len = first_len;
        end
        else
        begin
            res.tok0.kind = st_kind;
            res.tok0.len = st_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_START;
            line_reg <= LINE_WIDTH'(1);
            len_reg <= 8'd0;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            line_reg <= line_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            letters_reg[wr_idx] <= ch;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == ST_START) |-> (len_reg == 8'd0))
        else $error("start stage holds a nonzero token length");
    a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == ST_ID || stage_reg == ST_NUM) |-> (len_reg != 8'd0))
        else $error("identifier or number stage with empty text");
    a_line_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (line_reg >= $past(line_reg) && line_reg != '0))
        else $error("line count went backwards or reached zero");
`endif

endmodule

`default_nettype wire

/* rtl/cml_outq.sv */
`default_nettype none

module cml_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cml_pkg::scan_out_t  res,
    output logic                     space,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cml_pkg::entry_t          head
);

    localparam int DEPTH = cml_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cml_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [1:0]      push_n;
    logic            pop;
    cml_pkg::entry_t e0;
    cml_pkg::entry_t e1;

    assign push_n = push ? res.count : 2'd0;
    assign pop = out_valid && out_ready;
    assign space = (count_reg <= CW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        e0.kind = res.tok0.kind;
        e0.len = res.tok0.len;
        e0.line = res.line;
        e0.last = (res.count == 2'd1);
        e1.kind = res.tok1.kind;
        e1.len = res.tok1.len;
        e1.line = res.line;
        e1.last = 1'b1;
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= e0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PW'(1)] <= e1;
        end
    end

`ifndef NO_ASSERTIONS
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("token queue holds more entries than its depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("request taken without room for two tokens");
    a_pair_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2 && !pop) |=> (count_reg == $past(count_reg) + CW'(2)))
        else $error("two-token request did not add two entries");
`endif

endmodule

`default_nettype wire

/* rtl/cminus_lexer.sv */
`default_nettype none

// Lexical scanner for C-minus source text. One character request is taken per clock while
// the queue has room; the scan logic turns it into zero, one or two tokens, which go
// into a four-entry token queue that drives the output port. The input stays ready while
// the queue has room for two tokens, so a steady stream runs at one character per cycle
// while the output keeps up; a character that ends one token and is itself a one-character
// token delivers two tokens, which leave one after the other, since the single output port
// gives one token a cycle while out_ready is high. Tokens pass through the queue registers.
module cminus_lexer #(
    parameter int KEYWORD_CHARS = cml_pkg::KEYWORD_CHARS_DEF,
    parameter int LINE_WIDTH = cml_pkg::LINE_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       token_kind,
    output logic [15:0]      line_number,
    output logic [7:0]       token_length,
    output logic             last_of_run
);

    cml_pkg::scan_out_t res;
    cml_pkg::entry_t    head;
    logic               step;
    logic               space;

    assign in_ready = space;
    assign step = in_valid && space;

    cml_scan #(
        .KEYWORD_CHARS(KEYWORD_CHARS),
        .LINE_WIDTH(LINE_WIDTH)
    ) u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .ch(ch),
        .res(res)
    );

    cml_outq u_outq (
        .clk(clk),
        .rst_n(rst_n),
        .push(step),
        .res(res),
        .space(space),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .head(head)
    );

    assign token_kind = head.kind;
    assign line_number = head.line;
    assign token_length = head.len;
    assign last_of_run = head.last;

endmodule

`default_nettype wire
